### rtl/core/sfxva_pkg.sv
// Package: widths, codes and entry types for the sound-effect voice allocator.
package sfxva_pkg;
  localparam int EFFECT_VOICES = 4;
  localparam int MUSIC_VOICES  = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int DELAY_SLOTS   = 8;

  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = QA_W + 1;
  localparam int DS_W = $clog2(DELAY_SLOTS);
  localparam int EV_W = (EFFECT_VOICES > 1) ? $clog2(EFFECT_VOICES) : 1;

  typedef enum logic [1:0] {
    ACT_REQ  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_STOP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_START  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  delay;
    logic [7:0]  prio;
    logic [15:0] tag;
  } qent_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] tag;
  } dreq_t;
endpackage

### rtl/core/sfx_voice_allocator.sv
// Top level: sound-effect voice allocator with queue, delay slots and stealing.
// Request, stop-all, unknown action: one result, registered in the emit state.
// Tick: countdown over every delay slot, then per queue entry a queue memory read
// and then its use (a start attempt, or a move to a free delay slot), then done.
// One item at a time; the next item is taken once the done result is registered.
// Reset (rst_n low, synchronous) clears counters, slots, priorities and ages.
module sfx_voice_allocator
  import sfxva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] action, [17:2] sound_tag, [18] has_waveform, [26:19] priority_req,
  // [34:27] delay_blocks, [38:35] voice_busy_mask
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] kind, [5:2] voice_number, [21:6] started_tag
  output logic [23:0] out_tdata,
  output logic        out_tlast
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SLOT  = 6'b000010,
    S_QRD   = 6'b000100,
    S_QUSE  = 6'b001000,
    S_DONE  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  qent_t queue_mem [QUEUE_DEPTH];
  qent_t q_rd_r;
  dreq_t dslot_mem [DELAY_SLOTS];
  dreq_t d_rd_r;

  logic [QC_W-1:0] qwc_r, qrc_r;
  logic [DELAY_SLOTS-1:0] dact_r;
  logic [7:0] drem_r [DELAY_SLOTS];
  logic [7:0] vprio_r [EFFECT_VOICES];
  logic [31:0] vage_r [EFFECT_VOICES];
  logic [31:0] age_r;
  logic [EFFECT_VOICES-1:0] busy_r;
  logic [DS_W:0] slot_r;
  logic slot_go_r;

  logic [23:0] od_r;
  logic ov_r, ol_r;

  action_t act;
  logic [15:0] i_tag;
  logic i_wave;
  logic [7:0] i_prio, i_delay;
  logic [EFFECT_VOICES-1:0] i_busy;
  assign act    = action_t'(in_tdata[1:0]);
  assign i_tag  = in_tdata[17:2];
  assign i_wave = in_tdata[18];
  assign i_prio = in_tdata[26:19];
  assign i_delay = in_tdata[34:27];
  assign i_busy = in_tdata[35 +: EFFECT_VOICES];

  logic [QC_W-1:0] fill;
  assign fill = qwc_r - qrc_r;

  logic in_xfer, out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_xfer = in_tvalid && in_tready;

  // voice selection for the candidate in flight
  logic [EV_W-1:0] free_idx, vic_idx;
  logic any_free;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int s = EFFECT_VOICES - 1; s >= 0; s--) begin
      if (!busy_r[s]) begin
        any_free = 1'b1;
        free_idx = EV_W'(s);
      end
    end
    vic_idx = '0;
    for (int s = 1; s < EFFECT_VOICES; s++) begin
      if (vprio_r[s] < vprio_r[vic_idx] ||
          (vprio_r[s] == vprio_r[vic_idx] && vage_r[s] < vage_r[vic_idx]))
        vic_idx = EV_W'(s);
    end
  end

  // first free delay slot
  logic [DS_W-1:0] free_slot;
  logic any_slot;
  always_comb begin
    any_slot = 1'b0;
    free_slot = '0;
    for (int i = DELAY_SLOTS - 1; i >= 0; i--) begin
      if (!dact_r[i]) begin
        any_slot = 1'b1;
        free_slot = DS_W'(i);
      end
    end
  end

  // candidate start
  logic cand_v;
  logic [15:0] cand_tag;
  logic [7:0] cand_prio;
  logic [EV_W-1:0] sel;
  logic do_start;
  always_comb begin
    cand_v = 1'b0;
    cand_tag = d_rd_r.tag;
    cand_prio = d_rd_r.prio;
    if (state_r == S_SLOT && slot_go_r) cand_v = 1'b1;
    if (state_r == S_QUSE && q_rd_r.delay == 8'd0) begin
      cand_v = 1'b1;
      cand_tag = q_rd_r.tag;
      cand_prio = q_rd_r.prio;
    end
    sel = any_free ? free_idx : vic_idx;
    do_start = cand_v && (any_free || !(cand_prio < vprio_r[vic_idx]));
  end

  logic [DS_W-1:0] slot_idx;
  assign slot_idx = slot_r[DS_W-1:0];
  logic slot_hit;
  logic [7:0] slot_dec;
  always_comb begin
    slot_dec = (drem_r[slot_idx] > 8'd0) ? drem_r[slot_idx] - 8'd1 : 8'd0;
    slot_hit = dact_r[slot_idx] && (slot_dec == 8'd0);
  end

  // a stall on the output holds the sequencer
  logic hold;
  assign hold = ov_r && !out_tready && (do_start || state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = (act == ACT_TICK) ? S_SLOT : S_EMIT;
      S_SLOT: if (!hold && slot_r == (DS_W + 1)'(DELAY_SLOTS)) state_nxt = S_QRD;
      S_QRD:  state_nxt = (fill == '0) ? S_DONE : S_QUSE;
      S_QUSE: if (!hold) state_nxt = S_QRD;
      S_DONE: if (!hold) state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_xfer && act == ACT_REQ && i_wave && fill < QC_W'(QUEUE_DEPTH))
      queue_mem[qwc_r[QA_W-1:0]] <= '{delay: i_delay, prio: i_prio, tag: i_tag};
    // hold the fetched entry while a start waits on the output
    if (state_r == S_QRD) q_rd_r <= queue_mem[qrc_r[QA_W-1:0]];
    if (state_r == S_QUSE && !hold && q_rd_r.delay != 8'd0 && any_slot)
      dslot_mem[free_slot] <= '{prio: q_rd_r.prio, tag: q_rd_r.tag};
    if (state_r == S_SLOT && !hold) d_rd_r <= dslot_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qwc_r <= '0;
      qrc_r <= '0;
      dact_r <= '0;
      age_r <= '0;
      busy_r <= '0;
      slot_r <= '0;
      slot_go_r <= 1'b0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
      od_r <= '0;
      for (int i = 0; i < DELAY_SLOTS; i++) drem_r[i] <= '0;
      for (int v = 0; v < EFFECT_VOICES; v++) begin
        vprio_r[v] <= '0;
        vage_r[v] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (in_xfer) begin
        slot_r <= '0;
        slot_go_r <= 1'b0;
        ol_r <= 1'b1;
        od_r <= {22'd0, KIND_DONE};
        unique case (act)
          ACT_REQ: begin
            if (i_wave && fill < QC_W'(QUEUE_DEPTH)) begin
              qwc_r <= qwc_r + 1'b1;
              od_r <= {22'd0, KIND_ACCEPT};
            end else od_r <= {22'd0, KIND_REJECT};
          end
          ACT_TICK: busy_r <= i_busy;
          ACT_STOP: begin
            qrc_r <= qwc_r;
            dact_r <= '0;
            for (int i = 0; i < DELAY_SLOTS; i++) drem_r[i] <= '0;
            for (int v = 0; v < EFFECT_VOICES; v++) begin
              vprio_r[v] <= '0;
              vage_r[v] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_r == S_EMIT && out_free) ov_r <= 1'b1;
      if (!hold && do_start) begin
        busy_r[sel] <= 1'b1;
        vprio_r[sel] <= cand_prio;
        vage_r[sel] <= age_r;
        age_r <= age_r + 32'd1;
        ov_r <= 1'b1;
        ol_r <= 1'b0;
        od_r <= {2'b00, cand_tag, 4'(MUSIC_VOICES + int'(sel)), KIND_START};
      end
      if (state_r == S_SLOT && !hold) begin
        slot_go_r <= 1'b0;
        if (slot_r != (DS_W + 1)'(DELAY_SLOTS)) begin
          if (dact_r[slot_idx]) drem_r[slot_idx] <= slot_dec;
          if (slot_hit) dact_r[slot_idx] <= 1'b0;
          slot_go_r <= slot_hit;
          slot_r <= slot_r + 1'b1;
        end
      end
      if (state_r == S_QRD && fill != '0) qrc_r <= qrc_r + 1'b1;
      if (state_r == S_QUSE && !hold && q_rd_r.delay != 8'd0 && any_slot) begin
        dact_r[free_slot] <= 1'b1;
        drem_r[free_slot] <= q_rd_r.delay;
      end
      if (state_r == S_DONE && !hold) begin
        od_r <= {22'd0, KIND_DONE};
        ol_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;
endmodule

### rtl/core/sfxva_checker.sv
// Port-level checker for the voice allocator, bound to the top level.
module sfxva_checker
  import sfxva_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_start_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_START |-> !out_tlast)
    else $error("start marked last");
  a_start_voice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_START |->
      out_tdata[5:2] >= 4'(MUSIC_VOICES))
    else $error("start on music voice");
  a_ans_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == KIND_ACCEPT || out_tdata[1:0] == KIND_REJECT ||
      out_tdata[1:0] == KIND_DONE) |-> out_tlast)
    else $error("answer not last");
endmodule

bind sfx_voice_allocator sfxva_checker u_sfxva_checker (.*);
